// ===== src/ons2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ons2d_pkg
// Shared constants and types for the 2-d opensimplex noise block.
// ----------------------------------------------------------------------------
package ons2d_pkg;

    // coordinate and result formats
    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 15;

    // 64-bit linear congruential generator
    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
    localparam int          SHUF_OFFSET = 31;

    // lattice skew constants in units of 2^-32
    localparam logic signed [31:0] STRETCH_Q32 = -32'sd907633386;
    localparam logic [31:0]        SQUISH_Q32  = 32'd1572067139;

    // output normalization: divide by 47 * 2^DIV_SHIFT with rounding
    localparam int          DIV_SHIFT   = 48 - OUT_FRAC_BITS;
    localparam logic [63:0] HALF_DEN    = 64'd47 << (DIV_SHIFT - 1);
    localparam logic [20:0] T_CLAMP     = 21'd1540096;   // 47 * 32768
    localparam logic [21:0] RECIP_47    = 22'd2855697;   // ceil(2^27 / 47)
    localparam int          RECIP_SHIFT = 27;

    // permutation table write from the seed sequencer
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_perm_wr;

endpackage

// ===== src/opensimplex_2d_noise.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opensimplex_2d_noise
// 2-d opensimplex gradient noise with a seeded permutation table.
// ----------------------------------------------------------------------------
// An evaluate word (command 1) enters the fifteen-stage pipeline and its
// result passes every stage into the output register; one evaluate word is
// taken every cycle while o_stall is low. A seed word (command 0) raises
// o_stall, waits for the pipeline to drain, and keeps o_stall high through a
// fill of all 256 scratch entries and then 256 shuffle steps, each set by the
// bit-serial remainder unit and the generator multiply of three partial
// products. Its result (noise 0, seed_done 1) follows all earlier results.
// Evaluate words must not be sent before the first seed word.
// ----------------------------------------------------------------------------
module opensimplex_2d_noise (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_noise_value,
    output logic               o_seed_done,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [63:0] r_seed_value;
    logic        r_seed_busy;
    logic        r_seed_pend;
    logic        r_seed_fin;
    logic        r_out_valid;
    logic signed [15:0] r_out_noise;
    logic        r_out_seed;

    logic        n_adv;
    logic        n_acc;
    logic        n_start;
    logic        n_seed_load;
    logic        eval_valid;
    logic        eval_busy;
    logic signed [15:0] eval_noise;
    logic        seed_done;
    ons2d_pkg::t_perm_wr perm_wr;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? r_seed_value : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= 64'd0;
        end else if (psel && penable && pwrite && (paddr[3] == 1'b0)) begin
            r_seed_value <= pwdata;
        end
    end

    assign n_adv       = !r_out_valid || !i_stall;
    assign o_stall     = r_seed_busy || !n_adv;
    assign n_acc       = i_valid && !o_stall;
    assign n_start     = r_seed_pend && !eval_busy;
    assign n_seed_load = r_seed_fin && n_adv;

    ons2d_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (n_adv),
        .i_valid       (n_acc && i_command),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_perm_wr     (perm_wr),
        .o_valid       (eval_valid),
        .o_noise_value (eval_noise),
        .o_busy        (eval_busy)
    );

    ons2d_seed u_seed (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_start),
        .i_seed    (r_seed_value),
        .o_perm_wr (perm_wr),
        .o_done    (seed_done)
    );

    // seed word: wait for drain, run the sequencer, then report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_busy <= 1'b0;
            r_seed_pend <= 1'b0;
            r_seed_fin  <= 1'b0;
        end else begin
            if (n_acc && !i_command) begin
                r_seed_busy <= 1'b1;
                r_seed_pend <= 1'b1;
            end else if (n_start) begin
                r_seed_pend <= 1'b0;
            end
            if (seed_done) begin
                r_seed_fin <= 1'b1;
            end else if (n_seed_load) begin
                r_seed_fin  <= 1'b0;
                r_seed_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            r_out_valid <= eval_valid || r_seed_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_out_noise <= r_seed_fin ? 16'sd0 : eval_noise;
            r_out_seed  <= r_seed_fin;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_noise;
    assign o_seed_done   = r_out_seed;

endmodule

// ===== src/ons2d_seed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ons2d_seed
// Seed sequencer: fills the scratch table, steps the generator with one
// shared 32x32 multiplier and shuffles into the permutation table using a
// bit-serial remainder unit.
// ----------------------------------------------------------------------------
module ons2d_seed (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_seed,
    output ons2d_pkg::t_perm_wr o_perm_wr,
    output logic               o_done
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FILL  = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_ADD   = 9'b000001000,
        ST_DINIT = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_READ  = 9'b001000000,
        ST_WRITE = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    t_state      r_state;
    logic [7:0]  r_idx;
    logic [1:0]  r_pre;
    logic [1:0]  r_ph;
    logic [5:0]  r_cnt;
    logic [63:0] r_s;
    logic [63:0] r_p0;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic        r_neg;
    logic [8:0]  r_rem;
    logic [63:0] r_dq;
    logic [7:0]  r_r;
    logic [7:0]  r_rd_r;
    logic [7:0]  r_rd_i;
    logic [7:0]  r_scratch [256];

    logic [31:0] n_opa;
    logic [31:0] n_opb;
    logic [63:0] n_mul;
    logic [8:0]  n_d;
    logic [9:0]  n_sh;
    logic [10:0] n_trial;
    logic [63:0] n_a;
    logic [7:0]  n_r;
    logic        n_sw_en;
    logic [7:0]  n_sw_addr;
    logic [7:0]  n_sw_data;

    // low 64 bits of s * LCG_MUL as three 32x32 partial products
    always_comb begin
        unique case (r_ph)
            2'd0: begin
                n_opa = r_s[31:0];
                n_opb = ons2d_pkg::LCG_MUL[31:0];
            end
            2'd1: begin
                n_opa = r_s[31:0];
                n_opb = ons2d_pkg::LCG_MUL[63:32];
            end
            default: begin
                n_opa = r_s[63:32];
                n_opb = ons2d_pkg::LCG_MUL[31:0];
            end
        endcase
        n_mul = {32'd0, n_opa} * {32'd0, n_opb};
    end

    assign n_d     = {1'b0, r_idx} + 9'd1;
    assign n_sh    = {r_rem, r_dq[63]};
    assign n_trial = {1'b0, n_sh} - {2'b0, n_d};
    assign n_a     = r_s + 64'(ons2d_pkg::SHUF_OFFSET);
    // negative dividend: fold the remainder back into range
    assign n_r     = (r_neg && (r_rem != 9'd0)) ? 8'(n_d - r_rem) : r_rem[7:0];

    always_comb begin
        n_sw_en   = 1'b0;
        n_sw_addr = r_idx;
        n_sw_data = r_idx;
        if (r_state == ST_FILL) begin
            n_sw_en = 1'b1;
        end else if (r_state == ST_WRITE) begin
            n_sw_en   = 1'b1;
            n_sw_addr = r_r;
            n_sw_data = r_rd_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_sw_en) begin
            r_scratch[n_sw_addr] <= n_sw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd_r <= r_scratch[n_r];
            r_rd_i <= r_scratch[r_idx];
            r_r    <= n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= 8'd0;
            r_pre   <= 2'd0;
            r_ph    <= 2'd0;
            r_cnt   <= 6'd0;
            r_s     <= 64'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_s     <= i_seed;
                        r_idx   <= 8'd0;
                        r_state <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    if (r_idx == 8'hFF) begin
                        r_pre   <= 2'd3;
                        r_ph    <= 2'd0;
                        r_state <= ST_MUL;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                ST_MUL: begin
                    unique case (r_ph)
                        2'd0:    r_p0 <= n_mul;
                        2'd1:    r_p1 <= n_mul[31:0];
                        default: r_p2 <= n_mul[31:0];
                    endcase
                    if (r_ph == 2'd2) begin
                        r_state <= ST_ADD;
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                ST_ADD: begin
                    r_s  <= r_p0 + {r_p1 + r_p2, 32'd0} + ons2d_pkg::LCG_INC;
                    r_ph <= 2'd0;
                    if (r_pre != 2'd0) begin
                        r_pre   <= r_pre - 2'd1;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_DINIT;
                    end
                end
                ST_DINIT: begin
                    r_neg   <= n_a[63];
                    r_dq    <= n_a[63] ? (~n_a + 64'd1) : n_a;
                    r_rem   <= 9'd0;
                    r_cnt   <= 6'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_trial[10] ? n_sh[8:0] : n_trial[8:0];
                    r_dq  <= {r_dq[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (r_idx == 8'd0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx   <= r_idx - 8'd1;
                        r_ph    <= 2'd0;
                        r_state <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_perm_wr.en   = (r_state == ST_WRITE);
    assign o_perm_wr.addr = r_idx;
    assign o_perm_wr.data = r_rd_r;
    assign o_done         = (r_state == ST_DONE);

endmodule

// ===== src/ons2d_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ons2d_eval
// Fifteen-stage evaluation pipeline: skew, region select, four contribution
// lanes each with its own copy of the permutation table, sum and normalize.
// ----------------------------------------------------------------------------
module ons2d_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_x_coord,
    input  logic signed [31:0]  i_y_coord,
    input  ons2d_pkg::t_perm_wr i_perm_wr,
    output logic                o_valid,
    output logic signed [15:0]  o_noise_value,
    output logic                o_busy
);

    localparam int STAGES = 15;
    localparam int LANES  = 4;

    localparam logic signed [35:0] ONE = 36'sh1_0000_0000;
    localparam logic signed [35:0] SQ  = 36'sd1572067139;
    localparam logic signed [35:0] RND = 36'sd128;   // half of one Q.24 step
    localparam logic signed [55:0] ATTN_TWO = 56'sh2_0000_0000_0000;

    typedef struct packed {
        logic signed [2:0]  ox;
        logic signed [2:0]  oy;
        logic signed [35:0] odx;
        logic signed [35:0] ody;
    } t_vtx;

    function automatic t_vtx vtx_sel(input logic [1:0] lane, input logic lo,
                                     input logic clo, input logic chi,
                                     input logic xgt);
        t_vtx v;
        v = '{3'sd0, 3'sd0, RND, RND};
        unique case (lane)
            2'd0: v = '{3'sd1, 3'sd0, -ONE - SQ + RND, -SQ + RND};
            2'd1: v = '{3'sd0, 3'sd1, -SQ + RND, -ONE - SQ + RND};
            2'd2: begin
                if (!lo) begin
                    v = '{3'sd1, 3'sd1, -ONE - 2*SQ + RND, -ONE - 2*SQ + RND};
                end
            end
            default: begin
                if (lo) begin
                    if (clo && xgt) begin
                        v = '{3'sd1, -3'sd1, -ONE + RND, ONE + RND};
                    end else if (clo) begin
                        v = '{-3'sd1, 3'sd1, ONE + RND, -ONE + RND};
                    end else begin
                        v = '{3'sd1, 3'sd1, -ONE - 2*SQ + RND, -ONE - 2*SQ + RND};
                    end
                end else if (chi && xgt) begin
                    v = '{3'sd2, 3'sd0, -2*ONE - 2*SQ + RND, -2*SQ + RND};
                end else if (chi) begin
                    v = '{3'sd0, 3'sd2, -2*SQ + RND, -2*ONE - 2*SQ + RND};
                end
            end
        endcase
        return v;
    endfunction

    // gradient pair {gx, gy} from perm bits [3:1]
    function automatic logic [7:0] grad(input logic [2:0] g);
        logic [7:0] r;
        unique case (g)
            3'd0:    r = {4'sd5,  4'sd2};
            3'd1:    r = {4'sd2,  4'sd5};
            3'd2:    r = {-4'sd5, 4'sd2};
            3'd3:    r = {-4'sd2, 4'sd5};
            3'd4:    r = {4'sd5,  -4'sd2};
            3'd5:    r = {4'sd2,  -4'sd5};
            3'd6:    r = {-4'sd5, -4'sd2};
            default: r = {-4'sd2, -4'sd5};
        endcase
        return r;
    endfunction

    logic [STAGES-1:0] r_vld;

    // stage 1
    logic signed [63:0] r1_prod;
    logic signed [31:0] r1_x, r1_y;
    // stage 2
    logic [7:0]  r2_xsb, r2_ysb;
    logic [31:0] r2_xins, r2_yins;
    // stage 3
    logic [63:0] r3_prod;
    logic [7:0]  r3_xsb, r3_ysb;
    logic [31:0] r3_xins, r3_yins;
    logic        r3_lo, r3_clo, r3_chi, r3_xgt;
    // stage 4
    logic [32:0]        r4_dx0, r4_dy0;
    logic [7:0]         r4_xv  [LANES];
    logic [7:0]         r4_yv  [LANES];
    logic signed [35:0] r4_odx [LANES];
    logic signed [35:0] r4_ody [LANES];
    // stage 5
    logic signed [27:0] r5_dx [LANES];
    logic signed [27:0] r5_dy [LANES];
    logic [7:0]         r5_h  [LANES];
    logic [7:0]         r5_yv [LANES];
    // stage 6
    logic [53:0]        r6_dx2 [LANES];
    logic [53:0]        r6_dy2 [LANES];
    logic signed [27:0] r6_dx  [LANES];
    logic signed [27:0] r6_dy  [LANES];
    logic [7:0]         r6_g   [LANES];
    // stage 7
    logic [25:0]        r7_a   [LANES];
    logic               r7_pos [LANES];
    logic signed [3:0]  r7_gx  [LANES];
    logic signed [3:0]  r7_gy  [LANES];
    logic signed [27:0] r7_dx  [LANES];
    logic signed [27:0] r7_dy  [LANES];
    // stage 8
    logic [26:0]        r8_a2  [LANES];
    logic signed [31:0] r8_dot [LANES];
    logic               r8_pos [LANES];
    // stage 9
    logic [28:0]        r9_a4  [LANES];
    logic signed [31:0] r9_dot [LANES];
    logic               r9_pos [LANES];
    // stage 10..15
    logic signed [61:0] r10_t [LANES];
    logic signed [62:0] r11_s01, r11_s23;
    logic signed [63:0] r12_sum;
    logic [20:0]        r13_t;
    logic               r13_neg;
    logic [42:0]        r14_p;
    logic               r14_neg;
    logic signed [15:0] r15_val;

    logic [7:0] r_perm [LANES][256];

    logic signed [32:0] n1_sum;
    logic signed [63:0] n1_prod;
    logic signed [63:0] n2_off, n2_xs, n2_ys;
    logic [32:0]        n3_insum;
    logic [33:0]        n3_sx, n3_sy;
    logic [63:0]        n3_prod;
    logic [31:0]        n4_sq;
    t_vtx               n4_v  [LANES];
    logic signed [35:0] n5_dx [LANES];
    logic signed [35:0] n5_dy [LANES];
    logic [7:0]         n6_addr [LANES];
    logic signed [55:0] n6_dx2 [LANES];
    logic signed [55:0] n6_dy2 [LANES];
    logic [7:0]         n7_gg  [LANES];
    logic signed [55:0] n7_attn [LANES];
    logic [51:0]        n8_aa  [LANES];
    logic signed [31:0] n8_dot [LANES];
    logic [53:0]        n9_aa  [LANES];
    logic signed [61:0] n10_t  [LANES];
    logic [63:0]        n13_mag, n13_t64;
    logic [20:0]        n13_t;
    logic [15:0]        n15_q;
    logic signed [15:0] n15_val;

    always_comb begin
        n1_sum  = {i_x_coord[31], i_x_coord} + {i_y_coord[31], i_y_coord};
        n1_prod = n1_sum * ons2d_pkg::STRETCH_Q32;

        n2_off = r1_prod >>> ons2d_pkg::COORD_FRAC_BITS;
        n2_xs  = ({{32{r1_x[31]}}, r1_x} <<< (32 - ons2d_pkg::COORD_FRAC_BITS)) + n2_off;
        n2_ys  = ({{32{r1_y[31]}}, r1_y} <<< (32 - ons2d_pkg::COORD_FRAC_BITS)) + n2_off;

        n3_insum = {1'b0, r2_xins} + {1'b0, r2_yins};
        n3_sx    = {1'b0, n3_insum} + {2'b0, r2_xins};
        n3_sy    = {1'b0, n3_insum} + {2'b0, r2_yins};
        n3_prod  = {31'd0, n3_insum} * {32'd0, ons2d_pkg::SQUISH_Q32};

        n4_sq = 32'((r3_prod + 64'h8000_0000) >> 32);

        for (int k = 0; k < LANES; k++) begin
            n4_v[k]    = vtx_sel(2'(k), r3_lo, r3_clo, r3_chi, r3_xgt);
            n5_dx[k]   = $signed({3'b0, r4_dx0}) + r4_odx[k];
            n5_dy[k]   = $signed({3'b0, r4_dy0}) + r4_ody[k];
            n6_addr[k] = r5_h[k] + r5_yv[k];
            n6_dx2[k]  = r5_dx[k] * r5_dx[k];
            n6_dy2[k]  = r5_dy[k] * r5_dy[k];
            n7_gg[k]   = grad(r6_g[k][3:1]);
            n7_attn[k] = ATTN_TWO - $signed({2'b0, r6_dx2[k]})
                       - $signed({2'b0, r6_dy2[k]});
            n8_aa[k]   = {26'd0, r7_a[k]} * {26'd0, r7_a[k]};
            n8_dot[k]  = r7_gx[k] * r7_dx[k] + r7_gy[k] * r7_dy[k];
            n9_aa[k]   = {27'd0, r8_a2[k]} * {27'd0, r8_a2[k]};
            n10_t[k]   = $signed({1'b0, r9_a4[k]}) * r9_dot[k];
        end

        // round half away from zero on the magnitude, then scale down
        n13_mag = r12_sum[63] ? (~r12_sum + 64'd1) : r12_sum;
        n13_t64 = (n13_mag + ons2d_pkg::HALF_DEN) >> ons2d_pkg::DIV_SHIFT;
        n13_t   = (n13_t64 >= {43'd0, ons2d_pkg::T_CLAMP}) ? ons2d_pkg::T_CLAMP
                                                           : n13_t64[20:0];

        n15_q = r14_p[ons2d_pkg::RECIP_SHIFT +: 16];
        if (r14_neg) begin
            n15_val = -$signed(n15_q);
        end else if (n15_q[15]) begin
            n15_val = 16'sh7FFF;
        end else begin
            n15_val = $signed(n15_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // one table copy per lane, all written alike while seeding
    always_ff @(posedge i_clk) begin
        if (i_perm_wr.en) begin
            for (int k = 0; k < LANES; k++) begin
                r_perm[k][i_perm_wr.addr] <= i_perm_wr.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r5_h[k] <= r_perm[k][r4_xv[k]];
                r6_g[k] <= r_perm[k][n6_addr[k]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= n1_prod;
            r1_x    <= i_x_coord;
            r1_y    <= i_y_coord;

            r2_xsb  <= n2_xs[39:32];
            r2_ysb  <= n2_ys[39:32];
            r2_xins <= n2_xs[31:0];
            r2_yins <= n2_ys[31:0];

            r3_prod <= n3_prod;
            r3_xsb  <= r2_xsb;
            r3_ysb  <= r2_ysb;
            r3_xins <= r2_xins;
            r3_yins <= r2_yins;
            r3_lo   <= ({1'b0, n3_insum} <= 34'h1_0000_0000);
            r3_clo  <= (n3_sx < 34'h1_0000_0000) || (n3_sy < 34'h1_0000_0000);
            r3_chi  <= (n3_sx > 34'h2_0000_0000) || (n3_sy > 34'h2_0000_0000);
            r3_xgt  <= (r2_xins > r2_yins);

            r4_dx0 <= {1'b0, r3_xins} + {1'b0, n4_sq};
            r4_dy0 <= {1'b0, r3_yins} + {1'b0, n4_sq};

            for (int k = 0; k < LANES; k++) begin
                r4_xv[k]  <= r3_xsb + {{5{n4_v[k].ox[2]}}, n4_v[k].ox};
                r4_yv[k]  <= r3_ysb + {{5{n4_v[k].oy[2]}}, n4_v[k].oy};
                r4_odx[k] <= n4_v[k].odx;
                r4_ody[k] <= n4_v[k].ody;

                r5_dx[k] <= n5_dx[k][35:8];
                r5_dy[k] <= n5_dy[k][35:8];
                r5_yv[k] <= r4_yv[k];

                r6_dx2[k] <= n6_dx2[k][53:0];
                r6_dy2[k] <= n6_dy2[k][53:0];
                r6_dx[k]  <= r5_dx[k];
                r6_dy[k]  <= r5_dy[k];

                r7_a[k]   <= n7_attn[k][49:24];
                r7_pos[k] <= (n7_attn[k] > 56'sd0);
                r7_gx[k]  <= $signed(n7_gg[k][7:4]);
                r7_gy[k]  <= $signed(n7_gg[k][3:0]);
                r7_dx[k]  <= r6_dx[k];
                r7_dy[k]  <= r6_dy[k];

                r8_a2[k]  <= n8_aa[k][50:24];
                r8_dot[k] <= n8_dot[k];
                r8_pos[k] <= r7_pos[k];

                r9_a4[k]  <= n9_aa[k][52:24];
                r9_dot[k] <= r8_dot[k];
                r9_pos[k] <= r8_pos[k];

                r10_t[k] <= r9_pos[k] ? n10_t[k] : 62'sd0;
            end

            r11_s01 <= {r10_t[0][61], r10_t[0]} + {r10_t[1][61], r10_t[1]};
            r11_s23 <= {r10_t[2][61], r10_t[2]} + {r10_t[3][61], r10_t[3]};
            r12_sum <= {r11_s01[62], r11_s01} + {r11_s23[62], r11_s23};

            r13_t   <= n13_t;
            r13_neg <= r12_sum[63];

            r14_p   <= {22'd0, r13_t} * {21'd0, ons2d_pkg::RECIP_47};
            r14_neg <= r13_neg;

            r15_val <= n15_val;
        end
    end

    assign o_valid       = r_vld[STAGES-1];
    assign o_noise_value = r15_val;
    assign o_busy        = |r_vld;

endmodule

// ===== src/ons2d_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ons2d_chk
// Port-level checks for the noise block, bound to the top level.
// ----------------------------------------------------------------------------
module ons2d_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_command,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_noise_value,
    input logic               o_seed_done
);

    // a held result word does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_value)
                              && $stable(o_seed_done))
        else $error("output word changed while stalled");

    a_seed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_seed_done |-> o_noise_value == 16'sd0)
        else $error("seed result carries nonzero noise");

    // o_stall rises once a seed word is taken, so the sequencer can own the tables
    a_seed_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_command |=> o_stall)
        else $error("input taken right after a seed word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind opensimplex_2d_noise ons2d_chk u_ons2d_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_noise_value (o_noise_value),
    .o_seed_done   (o_seed_done)
);
